// ----- rtl/fmr_pkg.sv -----
// Package for the FIFO with match-and-replace block.
// Holds operation and status codes, the controller state type and the cell control struct.
// No dependencies.
`default_nettype none

package fmr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 16;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;

  // operation codes
  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctl_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic            push;        // write push_value into the tail cell
    logic            pop;         // every cell but the last takes its upper neighbour's value; the last keeps its own
    logic            start;       // launch a scan token into cell 0
    logic [ID_W-1:0] push_value;
    logic [ID_W-1:0] scan_key;
    logic [ID_W-1:0] scan_repl;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/fmr_cell.sv -----
// One storage cell of the shifting queue.
// Holds one entry and the scan token; depends on fmr_pkg.
`default_nettype none

module fmr_cell
  import fmr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cell_ctl_t       ctl,
  input  wire logic            occ,      // this cell holds a live entry
  input  wire logic            at_tail,  // this cell is the next free slot
  input  wire logic [ID_W-1:0] data_up,  // value of the cell nearer the tail (own value in the last cell)
  input  wire logic            tok_in,
  output logic      [ID_W-1:0] data,
  output logic                 tok_out,
  output logic                 hit,
  output logic                 miss
);

  logic tok;
  logic eq;

  assign eq      = (data == ctl.scan_key);
  assign hit     = tok && occ && eq;
  assign miss    = tok && !occ;
  assign tok_out = tok && occ && !eq;

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      data <= data_up;
    end else if (ctl.push && at_tail) begin
      data <= ctl.push_value;
    end else if (hit) begin
      data <= ctl.scan_repl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fifo_with_match_replace_core.sv -----
// Top level of the bounded FIFO with match-and-replace.
// Controller, result register and a row of fmr_cell; depends on fmr_pkg and fmr_cell.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+--------------------------------------
//  in       | in_valid  | in_stall  | action, id_value, replacement_id
//  out      | out_valid | out_stall | status, popped_value, occupancy
//
// Push and pop give their result in the out register at the accepting edge.
// Modify sends a token from the head cell towards the tail, one cell per cycle; its result
// is registered when the token meets the first match or the first empty cell, or passes
// the last cell, and the controller returns to idle at that same edge.
// Reset (rst, synchronous) empties the queue; cell contents are left as they are.
// in_stall is high during a scan and while an unclaimed result waits in the out register.
`default_nettype none

module fifo_with_match_replace_core
  import fmr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [ID_W-1:0]   id_value,
  input  wire logic [ID_W-1:0]   replacement_id,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [STAT_W-1:0] status,
  output logic      [ID_W-1:0]   popped_value,
  output logic      [CW-1:0]     occupancy
);

  ctl_state_t      state, state_next;
  logic [CW-1:0]   count;        // entries held; cell i is live when i < count
  logic [ID_W-1:0] scan_key;
  logic [ID_W-1:0] scan_repl;
  cell_ctl_t       ctl;

  logic            accept;
  logic            full;
  logic            empty;
  logic            scan_done;
  logic            scan_hit;

  logic [ID_W-1:0] cell_data [DEPTH];
  logic [DEPTH:0]  tok_chain;
  logic [DEPTH-1:0] hit_vec;
  logic [DEPTH-1:0] miss_vec;
  logic [DEPTH-1:0] occ_vec;
  logic [DEPTH-1:0] tail_vec;

  // take a new item only when idle and the result slot is free or draining
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  assign ctl.push       = accept && (action == ACT_PUSH) && !full;
  assign ctl.pop        = accept && (action == ACT_POP) && !empty;
  assign ctl.start      = accept && (action == ACT_MODIFY);
  assign ctl.push_value = id_value;
  assign ctl.scan_key   = scan_key;
  assign ctl.scan_repl  = scan_repl;

  assign tok_chain[0] = ctl.start;

  // -------------------------------------------------------------------------
  // cell row: cell 0 is the head, entries shift towards it on a pop
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] up;

    assign occ_vec[i]  = (CW'(i) < count);
    assign tail_vec[i] = (count == CW'(i));

    if (i == DEPTH - 1) begin : g_last
      assign up = cell_data[i];
    end else begin : g_mid
      assign up = cell_data[i+1];
    end

    fmr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .occ     (occ_vec[i]),
      .at_tail (tail_vec[i]),
      .data_up (up),
      .tok_in  (tok_chain[i]),
      .data    (cell_data[i]),
      .tok_out (tok_chain[i+1]),
      .hit     (hit_vec[i]),
      .miss    (miss_vec[i])
    );
  end

  // token ends on a match, on the first empty cell, or past the last cell
  assign scan_hit  = |hit_vec;
  assign scan_done = scan_hit || (|miss_vec) || tok_chain[DEPTH];

  // -------------------------------------------------------------------------
  // controller
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctl.start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      scan_key  <= id_value;
      scan_repl <= replacement_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CW'(1);
    end else if (ctl.pop) begin
      count <= count - CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (action != ACT_MODIFY)) begin
      out_valid <= 1'b1;
    end else if ((state == S_SCAN) && scan_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (action != ACT_MODIFY)) begin
      case (action)
        ACT_PUSH: begin
          popped_value <= '0;
          if (full) begin
            status    <= ST_FULL;
            occupancy <= count;
          end else begin
            status    <= ST_OK;
            occupancy <= count + CW'(1);
          end
        end
        ACT_POP: begin
          if (empty) begin
            status       <= ST_EMPTY;
            popped_value <= '0;
            occupancy    <= count;
          end else begin
            status       <= ST_OK;
            popped_value <= cell_data[0];
            occupancy    <= count - CW'(1);
          end
        end
        default: begin
          status       <= ST_OK;
          popped_value <= '0;
          occupancy    <= count;
        end
      endcase
    end else if ((state == S_SCAN) && scan_done) begin
      popped_value <= '0;
      occupancy    <= count;
      status       <= scan_hit ? ST_OK : ST_NOT_FOUND;
    end
  end

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  a_tok_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_chain))
    else $error("more than one scan token in the row");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !out_valid)
    else $error("result pending while a scan runs");

  a_direct_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (action != ACT_MODIFY)) |=> out_valid)
    else $error("push or pop gave no result");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> (state == S_SCAN))
    else $error("modify did not enter the scan");

endmodule

`default_nettype wire
